// File: rtl/ring_fixed_point_alu_top_assert.svh
// Assertion helpers shared by the RTL; clock aclk, reset aresetn (active low)
`ifndef RING_FIXED_POINT_ALU_TOP_ASSERT_SVH
`define RING_FIXED_POINT_ALU_TOP_ASSERT_SVH

// same-cycle implication
`define RFPA_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RFPA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/rfpa_pkg.sv
package rfpa_pkg;

    localparam int DATA_WIDTH_DEF = 64;
    localparam int REG_W          = 64;
    localparam int KIND_W         = 3;
    localparam int SHIFT_W        = 7;
    localparam int RBITS_W        = 7;
    localparam int CFG_IDX_W      = 2;

    localparam logic [REG_W-1:0]   MODULUS_RST = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [REG_W-1:0]   SCALE_RST   = 64'd1048576;
    localparam logic [RBITS_W-1:0] RBITS_RST   = 7'd63;

    localparam logic [CFG_IDX_W-1:0] CFG_MODULUS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RBITS   = 2'd2;

    typedef enum logic [KIND_W-1:0] {
        KIND_ADD       = 3'd0,
        KIND_SUB       = 3'd1,
        KIND_MODMUL    = 3'd2,
        KIND_TRUNCMUL  = 3'd3,
        KIND_STRUNCMUL = 3'd4,
        KIND_SHIFT     = 3'd5,
        KIND_SSHIFT    = 3'd6,
        KIND_NEG       = 3'd7
    } kind_t;

    // op fields riding along the operand reduction
    typedef struct packed {
        logic [SHIFT_W-1:0] shift;
        kind_t              kind;
    } op_t;

    // control riding along multiply and division
    typedef struct packed {
        logic status;
        logic negout;
        logic use_scale;
    } ctl_t;

endpackage

// File: rtl/ring_fixed_point_alu_top.sv
// Fixed-point ring ALU: one operation per transfer on elements modulo ring_modulus.
// Input channel s_*: s_tuser carries the operation kind, s_tdata the operands and
// shift count. Result channel m_*: m_tdata carries the reduced result, m_tuser the
// status bit (set when a shift count exceeds ring_bits; the result is then 0).
// Configuration: cfg_we/cfg_index/cfg_wdata write modulus (0), fraction scale (1)
// and ring bits (2); write only while no item is in flight.
// Datapath: operand reduction (DATA_WIDTH divide stages), two prep stages, a
// two-stage multiply, scale division (2*DATA_WIDTH stages), modular reduction
// (2*DATA_WIDTH stages) and an output register; the dividers are bit-per-stage restoring.
// Throughput: one item per cycle while the pipeline advances (s_tready high).
// When m_tready is low with a result waiting, the pipeline keeps advancing while its
// last stage is empty, then freezes as a whole (s_tready low); nothing is lost.
// Reset (synchronous, aresetn low) empties the pipeline and restores the register
// defaults: modulus 2^63-1, scale 2^20, ring bits 63.
`include "ring_fixed_point_alu_top_assert.svh"

module ring_fixed_point_alu_top #(
    parameter int DATA_WIDTH = rfpa_pkg::DATA_WIDTH_DEF
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    // operand_a, operand_b, shift_amount (from bit 0 up)
    input  logic [((2*DATA_WIDTH+rfpa_pkg::SHIFT_W+7)/8)*8-1:0] s_tdata,
    // kind
    input  logic [rfpa_pkg::KIND_W-1:0]             s_tuser,
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    // result
    output logic [((DATA_WIDTH+7)/8)*8-1:0]         m_tdata,
    // status
    output logic                                    m_tuser,
    input  logic                                    cfg_we,
    input  logic [rfpa_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [rfpa_pkg::REG_W-1:0]              cfg_wdata
);

    localparam int W      = DATA_WIDTH;
    localparam int OUT_W  = ((W + 7) / 8) * 8;
    localparam int OP_W   = $bits(rfpa_pkg::op_t);
    localparam int CTL_W  = $bits(rfpa_pkg::ctl_t);
    localparam logic [W-1:0] ONE     = W'(1);
    localparam logic [W-1:0] TWO     = W'(2);
    localparam logic [W-1:0] M_RST_T = rfpa_pkg::MODULUS_RST[W-1:0];
    localparam logic [W-1:0] F_RST_T = rfpa_pkg::SCALE_RST[W-1:0];
    localparam logic [W-1:0] M_RST   = (M_RST_T < TWO) ? TWO : M_RST_T;
    localparam logic [W-1:0] F_RST   = (F_RST_T == '0) ? ONE : F_RST_T;

    // configuration, held in effective form
    logic [W-1:0]                     mod_reg;
    logic [W-1:0]                     scale_reg;
    logic [rfpa_pkg::RBITS_W-1:0]     rbits_reg;
    logic [W-1:0]                     wr_trunc;
    logic [W-1:0]                     half;

    assign wr_trunc = cfg_wdata[W-1:0];
    assign half     = mod_reg >> 1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mod_reg   <= M_RST;
            scale_reg <= F_RST;
            rbits_reg <= rfpa_pkg::RBITS_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                rfpa_pkg::CFG_MODULUS: mod_reg   <= (wr_trunc < TWO) ? TWO : wr_trunc;
                rfpa_pkg::CFG_SCALE:   scale_reg <= (wr_trunc == '0) ? ONE : wr_trunc;
                rfpa_pkg::CFG_RBITS:   rbits_reg <= cfg_wdata[rfpa_pkg::RBITS_W-1:0];
                default: ;
            endcase
        end
    end

    // global pipeline advance
    logic adv;
    logic out_vld_reg;
    logic [W-1:0] out_res_reg;
    logic out_status_reg;
    logic div3_vld;

    assign adv      = !out_vld_reg || m_tready || !div3_vld;
    assign s_tready = adv;

    // operand reduction
    rfpa_pkg::op_t          in_op;
    logic [1:0][W-1:0]      red_dividend;
    logic                   red_vld;
    logic [1:0][W-1:0]      red_quot;
    logic [1:0][W-1:0]      red_rem;
    logic [OP_W-1:0]        red_side;
    rfpa_pkg::op_t          red_op;

    assign in_op.kind      = rfpa_pkg::kind_t'(s_tuser);
    assign in_op.shift     = s_tdata[2*W +: rfpa_pkg::SHIFT_W];
    assign red_dividend[0] = s_tdata[W-1:0];
    assign red_dividend[1] = s_tdata[2*W-1:W];
    assign red_op          = rfpa_pkg::op_t'(red_side);

    rfpa_divider #(.W(W), .NB(W), .LANES(2), .SIDE_W(OP_W)) u_reduce (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .en           (adv),
        .in_valid     (s_tvalid && s_tready),
        .in_dividend  (red_dividend),
        .in_divisor   (mod_reg),
        .in_side      (OP_W'(in_op)),
        .out_valid    (red_vld),
        .out_quotient (red_quot),
        .out_remainder(red_rem),
        .out_side     (red_side)
    );

    // prep stage 1: signs, negations, shift range check
    logic                   p1_vld_reg;
    logic [W-1:0]           p1_a_reg, p1_b_reg, p1_nega_reg, p1_negb_reg;
    logic                   p1_na_reg, p1_nb_reg, p1_err_reg;
    rfpa_pkg::op_t          p1_op_reg;
    logic                   is_shift;

    assign is_shift = (red_op.kind == rfpa_pkg::KIND_SHIFT)
                   || (red_op.kind == rfpa_pkg::KIND_SSHIFT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_vld_reg <= 1'b0;
        end else if (adv) begin
            p1_vld_reg <= red_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p1_a_reg    <= red_rem[0];
            p1_b_reg    <= red_rem[1];
            p1_nega_reg <= (red_rem[0] == '0) ? '0 : mod_reg - red_rem[0];
            p1_negb_reg <= (red_rem[1] == '0) ? '0 : mod_reg - red_rem[1];
            p1_na_reg   <= red_rem[0] >= half;
            p1_nb_reg   <= red_rem[1] >= half;
            p1_err_reg  <= is_shift && (red_op.shift > rbits_reg);
            p1_op_reg   <= red_op;
        end
    end

    // prep stage 2: multiplier operands and control per kind
    logic                   p2_vld_reg;
    logic [W-1:0]           p2_x_reg, p2_y_reg, p2_add_reg;
    rfpa_pkg::ctl_t         p2_ctl_reg;
    logic [W-1:0]           x_next, y_next, add_next, sh_src, sh_val;
    rfpa_pkg::ctl_t         ctl_next;

    assign sh_src = (p1_op_reg.kind == rfpa_pkg::KIND_SSHIFT && p1_na_reg) ? p1_nega_reg
                                                                             : p1_a_reg;
    assign sh_val = sh_src >> p1_op_reg.shift;

    always_comb begin
        x_next             = p1_a_reg;
        y_next             = ONE;
        add_next           = '0;
        ctl_next.status    = 1'b0;
        ctl_next.negout    = 1'b0;
        ctl_next.use_scale = 1'b0;
        case (p1_op_reg.kind)
            rfpa_pkg::KIND_ADD: begin
                add_next = p1_b_reg;
            end
            rfpa_pkg::KIND_SUB: begin
                add_next = p1_negb_reg;
            end
            rfpa_pkg::KIND_MODMUL: begin
                y_next = p1_b_reg;
            end
            rfpa_pkg::KIND_TRUNCMUL: begin
                y_next             = p1_b_reg;
                ctl_next.use_scale = 1'b1;
            end
            rfpa_pkg::KIND_STRUNCMUL: begin
                x_next             = p1_na_reg ? p1_nega_reg : p1_a_reg;
                y_next             = p1_nb_reg ? p1_negb_reg : p1_b_reg;
                ctl_next.negout    = p1_na_reg ^ p1_nb_reg;
                ctl_next.use_scale = 1'b1;
            end
            rfpa_pkg::KIND_SHIFT: begin
                x_next          = p1_err_reg ? '0 : sh_val;
                ctl_next.status = p1_err_reg;
            end
            rfpa_pkg::KIND_SSHIFT: begin
                x_next          = p1_err_reg ? '0 : sh_val;
                ctl_next.status = p1_err_reg;
                ctl_next.negout = p1_na_reg && !p1_err_reg;
            end
            rfpa_pkg::KIND_NEG: begin
                ctl_next.negout = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p2_vld_reg <= 1'b0;
        end else if (adv) begin
            p2_vld_reg <= p1_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p2_x_reg   <= x_next;
            p2_y_reg   <= y_next;
            p2_add_reg <= add_next;
            p2_ctl_reg <= ctl_next;
        end
    end

    // multiply
    logic                   mul_vld;
    logic [2*W-1:0]         mul_prod;
    logic [CTL_W-1:0]       mul_side;
    rfpa_pkg::ctl_t         mul_ctl;

    assign mul_ctl = rfpa_pkg::ctl_t'(mul_side);

    rfpa_mul #(.W(W), .SIDE_W(CTL_W)) u_mul (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (adv),
        .in_valid   (p2_vld_reg),
        .in_x       (p2_x_reg),
        .in_y       (p2_y_reg),
        .in_addend  (p2_add_reg),
        .in_side    (CTL_W'(p2_ctl_reg)),
        .out_valid  (mul_vld),
        .out_product(mul_prod),
        .out_side   (mul_side)
    );

    // division by the fraction scale (by one for other kinds)
    logic                   div2_vld;
    logic [0:0][2*W-1:0]    div2_quot;
    logic [0:0][W-1:0]      div2_rem;
    logic [CTL_W-1:0]       div2_side;

    rfpa_divider #(.W(W), .NB(2*W), .LANES(1), .SIDE_W(CTL_W)) u_scale_div (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .en           (adv),
        .in_valid     (mul_vld),
        .in_dividend  (mul_prod),
        .in_divisor   (mul_ctl.use_scale ? scale_reg : ONE),
        .in_side      (mul_side),
        .out_valid    (div2_vld),
        .out_quotient (div2_quot),
        .out_remainder(div2_rem),
        .out_side     (div2_side)
    );

    // reduction modulo the ring modulus
    logic [0:0][2*W-1:0]    div3_quot;
    logic [0:0][W-1:0]      div3_rem;
    logic [CTL_W-1:0]       div3_side;
    rfpa_pkg::ctl_t         div3_ctl;

    assign div3_ctl = rfpa_pkg::ctl_t'(div3_side);

    rfpa_divider #(.W(W), .NB(2*W), .LANES(1), .SIDE_W(CTL_W)) u_mod_div (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .en           (adv),
        .in_valid     (div2_vld),
        .in_dividend  (div2_quot),
        .in_divisor   (mod_reg),
        .in_side      (div2_side),
        .out_valid    (div3_vld),
        .out_quotient (div3_quot),
        .out_remainder(div3_rem),
        .out_side     (div3_side)
    );

    // final negation and output register
    logic [W-1:0] res_next;

    assign res_next = (div3_ctl.negout && div3_rem[0] != '0) ? mod_reg - div3_rem[0]
                                                              : div3_rem[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (adv && div3_vld) begin
            out_vld_reg <= 1'b1;
        end else if (m_tready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && div3_vld) begin
            out_res_reg    <= res_next;
            out_status_reg <= div3_ctl.status;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = OUT_W'(out_res_reg);
    assign m_tuser  = out_status_reg;

    `RFPA_ASSERT_IMPLY(a_err_zero, out_vld_reg && out_status_reg, out_res_reg == '0,
        "error status with nonzero result")
    `RFPA_ASSERT_IMPLY(a_res_in_ring, out_vld_reg, out_res_reg < mod_reg,
        "result not reduced below modulus")
    `RFPA_ASSERT_IMPLY(a_rem_in_ring, div3_vld, div3_rem[0] < mod_reg,
        "modular reduction remainder out of range")

endmodule

// File: rtl/rfpa_divider.sv
// Restoring division, one quotient bit per pipeline stage.
module rfpa_divider #(
    parameter int W      = 64,
    parameter int NB     = 64,
    parameter int LANES  = 1,
    parameter int SIDE_W = 1
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic [LANES-1:0][NB-1:0]     in_dividend,
    input  logic [W-1:0]                 in_divisor,
    input  logic [SIDE_W-1:0]            in_side,
    output logic                         out_valid,
    output logic [LANES-1:0][NB-1:0]     out_quotient,
    output logic [LANES-1:0][W-1:0]      out_remainder,
    output logic [SIDE_W-1:0]            out_side
);

    logic                      vld_reg  [NB];
    logic [LANES-1:0][W-1:0]   rem_reg  [NB];
    logic [LANES-1:0][NB-1:0]  nq_reg   [NB];   // dividend shifting out, quotient in
    logic [W-1:0]              dvs_reg  [NB];
    logic [SIDE_W-1:0]         side_reg [NB];

    for (genvar i = 0; i < NB; i++) begin : g_stage
        logic                     vld_src;
        logic [LANES-1:0][W-1:0]  rem_src;
        logic [LANES-1:0][NB-1:0] nq_src;
        logic [W-1:0]             dvs_src;
        logic [SIDE_W-1:0]        side_src;
        logic [LANES-1:0][W-1:0]  rem_next;
        logic [LANES-1:0][NB-1:0] nq_next;

        if (i == 0) begin : g_first
            assign vld_src  = in_valid;
            assign rem_src  = '0;
            assign nq_src   = in_dividend;
            assign dvs_src  = in_divisor;
            assign side_src = in_side;
        end else begin : g_rest
            assign vld_src  = vld_reg[i-1];
            assign rem_src  = rem_reg[i-1];
            assign nq_src   = nq_reg[i-1];
            assign dvs_src  = dvs_reg[i-1];
            assign side_src = side_reg[i-1];
        end

        always_comb begin
            logic [W:0] r2;
            logic       ge;
            for (int l = 0; l < LANES; l++) begin
                r2 = {rem_src[l], nq_src[l][NB-1]};
                ge = (r2 >= {1'b0, dvs_src});
                if (ge) begin
                    r2 = r2 - {1'b0, dvs_src};
                end
                rem_next[l] = r2[W-1:0];
                nq_next[l]  = {nq_src[l][NB-2:0], ge};
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[i] <= 1'b0;
            end else if (en) begin
                vld_reg[i] <= vld_src;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[i]  <= rem_next;
                nq_reg[i]   <= nq_next;
                dvs_reg[i]  <= dvs_src;
                side_reg[i] <= side_src;
            end
        end
    end

    assign out_valid     = vld_reg[NB-1];
    assign out_quotient  = nq_reg[NB-1];
    assign out_remainder = rem_reg[NB-1];
    assign out_side      = side_reg[NB-1];

endmodule

// File: rtl/rfpa_mul.sv
// Two-stage W x W multiply from four half-width partial products, plus an addend.
module rfpa_mul #(
    parameter int W      = 64,
    parameter int SIDE_W = 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic [W-1:0]      in_x,
    input  logic [W-1:0]      in_y,
    input  logic [W-1:0]      in_addend,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [2*W-1:0]    out_product,
    output logic [SIDE_W-1:0] out_side
);

    localparam int L = W / 2;
    localparam int H = W - L;

    logic                  s1_vld_reg;
    logic [2*L-1:0]        ll_reg;
    logic [W-1:0]          lh_reg;
    logic [W-1:0]          hl_reg;
    logic [2*H-1:0]        hh_reg;
    logic [W-1:0]          add_reg;
    logic [SIDE_W-1:0]     s1_side_reg;

    logic                  s2_vld_reg;
    logic [2*W-1:0]        prod_reg;
    logic [SIDE_W-1:0]     s2_side_reg;
    logic [2*W-1:0]        prod_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
        end else if (en) begin
            s1_vld_reg <= in_valid;
            s2_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ll_reg      <= in_x[L-1:0] * in_y[L-1:0];
            lh_reg      <= in_x[L-1:0] * in_y[W-1:L];
            hl_reg      <= in_x[W-1:L] * in_y[L-1:0];
            hh_reg      <= in_x[W-1:L] * in_y[W-1:L];
            add_reg     <= in_addend;
            s1_side_reg <= in_side;
        end
    end

    assign prod_next = (2*W)'(ll_reg)
                     + ((2*W)'(lh_reg) << L)
                     + ((2*W)'(hl_reg) << L)
                     + ((2*W)'(hh_reg) << (2*L))
                     + (2*W)'(add_reg);

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg    <= prod_next;
            s2_side_reg <= s1_side_reg;
        end
    end

    assign out_valid   = s2_vld_reg;
    assign out_product = prod_reg;
    assign out_side    = s2_side_reg;

endmodule

// File: tb/ring_fixed_point_alu_checker.sv
module ring_fixed_point_alu_checker
    import rfpa_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [135:0] s_tdata,
    input  logic [2:0]   s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [63:0]  m_tdata,
    input  logic         m_tuser,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [63:0]  cfg_wdata,
    output int           fail_count,
    output int           pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [63:0] result;
        logic        status;
    } alu_result_t;

    logic [63:0] modulus_q, scale_q;
    logic [6:0]  rbits_q;
    alu_result_t result_fifo[$];

    function automatic logic [63:0] rneg(logic [63:0] x, logic [63:0] m);
        return (x == 0) ? 64'd0 : m - x;
    endfunction

    function automatic logic [63:0] scaled_mul(logic [63:0] x, logic [63:0] y,
                                               logic [63:0] m);
        logic [127:0] p;
        logic [63:0]  f;
        f = (scale_q == 0) ? 64'd1 : scale_q;
        p = {64'd0, x} * {64'd0, y};
        p = p / {64'd0, f};
        return 64'(p % {64'd0, m});
    endfunction

    function automatic alu_result_t compute_alu(kind_t k, logic [63:0] ia,
                                                logic [63:0] ib, logic [6:0] s);
        alu_result_t r;
        logic [63:0] m, half, a, b, aa, ab, mag;
        logic [64:0] sum;
        m = (modulus_q < 2) ? 64'd2 : modulus_q;
        half = m / 2;
        a = ia % m;
        b = ib % m;
        r = '0;
        case (k)
            KIND_ADD: begin
                sum = {1'b0, a} + {1'b0, b};
                r.result = 64'(sum % {1'b0, m});
            end
            KIND_SUB: begin
                sum = {1'b0, a} + {1'b0, rneg(b, m)};
                r.result = 64'(sum % {1'b0, m});
            end
            KIND_MODMUL: r.result = 64'(({64'd0, a} * {64'd0, b}) % {64'd0, m});
            KIND_TRUNCMUL: r.result = scaled_mul(a, b, m);
            KIND_STRUNCMUL: begin
                aa = (a >= half) ? rneg(a, m) : a;
                ab = (b >= half) ? rneg(b, m) : b;
                r.result = scaled_mul(aa, ab, m);
                if ((a >= half) != (b >= half)) r.result = rneg(r.result, m);
            end
            KIND_SHIFT, KIND_SSHIFT: begin
                if (s > rbits_q) begin
                    r.status = 1'b1;
                end else if (k == KIND_SSHIFT && a >= half) begin
                    mag = (s >= 64) ? 64'd0 : (m - a) >> s;
                    r.result = rneg(mag, m);
                end else begin
                    r.result = (s >= 64) ? 64'd0 : a >> s;
                end
            end
            default: r.result = rneg(a, m);
        endcase
        return r;
    endfunction

    always @(posedge aclk) begin
        alu_result_t exp_r;
        if (!aresetn) begin
            modulus_q <= MODULUS_RST;
            scale_q <= SCALE_RST;
            rbits_q <= RBITS_RST;
            fail_count <= 0;
            pending <= 0;
            result_fifo.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_MODULUS: modulus_q <= cfg_wdata;
                    CFG_SCALE: scale_q <= cfg_wdata;
                    CFG_RBITS: rbits_q <= cfg_wdata[6:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                result_fifo.push_back(compute_alu(kind_t'(s_tuser), s_tdata[63:0],
                                                  s_tdata[127:64], s_tdata[134:128]));
            if (m_tvalid && m_tready) begin
                if (result_fifo.size() == 0) begin
                    if (fail_count < 10) $display("unexpected result %h", m_tdata);
                    fail_count <= fail_count + 1;
                end else begin
                    exp_r = result_fifo.pop_front();
                    if (exp_r.result !== m_tdata || exp_r.status !== m_tuser) begin
                        if (fail_count < 10)
                            $display("mismatch: exp %h/%b got %h/%b", exp_r.result,
                                     exp_r.status, m_tdata, m_tuser);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            pending <= result_fifo.size();
        end
    end
endmodule

// File: tb/ring_fixed_point_alu_top_tb.sv
module ring_fixed_point_alu_top_tb;
    import rfpa_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY = 5 * 64 + 5;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0, s_tready;
    logic [135:0] s_tdata = '0;
    logic [2:0]   s_tuser = '0;
    logic         m_tvalid, m_tready = 1'b0;
    logic [63:0]  m_tdata;
    logic         m_tuser;
    logic         cfg_we = 1'b0;
    logic [1:0]   cfg_index = '0;
    logic [63:0]  cfg_wdata = '0;
    int           fail_count, pending;
    int           cycle = 0;
    logic         drain_idle = 1'b1;
    logic         hold_rx = 1'b0;
    logic         hold_go = 1'b0;
    logic         src_calm = 1'b0;

    ring_fixed_point_alu_top dut (.*);

    ring_fixed_point_alu_checker chk (.*);

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle <= cycle + 1;
        if (cycle > 2_000_000) begin
            $display("** ring_fixed_point_alu_top: FAILED **");
            $finish;
        end
    end

    // receiver: random stall, calm stretch, one long hold-off
    always @(posedge aclk) begin
        if (hold_rx)
            m_tready <= 1'b0;
        else if (drain_idle)
            m_tready <= 1'b1;
        else
            m_tready <= ($urandom_range(99) >= 34);
    end

    // long hold-off while the sender keeps going, long enough to fill the pipeline
    initial begin
        wait (hold_go);
        hold_rx <= 1'b1;
        repeat (900) @(posedge aclk);
        hold_rx <= 1'b0;
    end

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [63:0] edge64();
        case ($urandom_range(5))
            0: return 64'd0;
            1: return 64'hFFFF_FFFF_FFFF_FFFF;
            2: return 64'h8000_0000_0000_0000;
            3: return 64'd1;
            4: return rand64() >> $urandom_range(63);
            default: return rand64();
        endcase
    endfunction

    task automatic send_op(kind_t k, logic [63:0] a, logic [63:0] b, logic [6:0] s);
        if (!src_calm) begin
            while ($urandom_range(99) < 34) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tuser <= k;
        s_tdata <= {1'b0, s, b, a};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic wait_drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (LATENCY + 20) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [63:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic random_ops(int n);
        logic [6:0] s;
        for (int i = 0; i < n; i++) begin
            s = ($urandom_range(3) == 0) ? 7'($urandom()) : 7'($urandom_range(70));
            send_op(kind_t'($urandom_range(7)), edge64(), edge64(), s);
        end
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        drain_idle <= 1'b1;
        src_calm = 1'b1;
        // directed: all kinds on extremes at reset settings
        for (int k = 0; k < 8; k++) begin
            send_op(kind_t'(k), 64'd0, 64'hFFFF_FFFF_FFFF_FFFF, 7'd0);
            send_op(kind_t'(k), 64'h7FFF_FFFF_FFFF_FFFE, 64'h4000_0000_0000_0000, 7'd63);
        end
        send_op(KIND_SHIFT, 64'h1234, 0, 7'd64);
        send_op(KIND_SSHIFT, 64'h7FFF_FFFF_FFFF_FFF0, 0, 7'd62);
        send_op(KIND_SSHIFT, 64'h7FFF_FFFF_FFFF_FFFE, 0, 7'd1);
        send_op(KIND_SHIFT, 64'h5, 0, 7'd127);
        // back to back on both sides
        random_ops(100);
        wait_drain();
        src_calm = 1'b0;
        drain_idle <= 1'b0;
        // extremes: tiny modulus, zero scale, 64-bit shifts allowed
        write_reg(CFG_MODULUS, 64'd0);
        write_reg(CFG_SCALE, 64'd0);
        write_reg(CFG_RBITS, 64'd64);
        send_op(KIND_SSHIFT, 64'd1, 0, 7'd64);
        send_op(KIND_NEG, 64'd3, 0, 7'd0);
        random_ops(80);
        wait_drain();
        write_reg(CFG_MODULUS, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(CFG_SCALE, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(CFG_RBITS, 64'd127);
        random_ops(80);
        wait_drain();
        write_reg(CFG_MODULUS, 64'd2);
        write_reg(CFG_SCALE, 64'd1);
        write_reg(CFG_RBITS, 64'd1);
        random_ops(80);
        wait_drain();
        write_reg(CFG_MODULUS, rand64() | 64'h10);
        write_reg(CFG_SCALE, 64'd1 << $urandom_range(40));
        write_reg(CFG_RBITS, 64'($urandom_range(1, 64)));
        hold_go = 1'b1;
        random_ops(450);
        wait_drain();
        if (fail_count == 0)
            $display("** ring_fixed_point_alu_top: PASSED **");
        else
            $display("** ring_fixed_point_alu_top: FAILED **");
        $finish;
    end
endmodule
